// ===== design/int64_divide_remainder_defines.svh =====
// assertion helpers shared by the divider rtl
`ifndef INT64_DIVIDE_REMAINDER_DEFINES_SVH
`define INT64_DIVIDE_REMAINDER_DEFINES_SVH

// same-cycle implication, checking disabled while in reset
`define IDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("divider assertion failed");

// next-cycle implication, checking disabled while in reset
`define IDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("divider assertion failed");

`endif

// ===== design/idr_pkg.sv =====
package idr_pkg;

	// port field width, fixed
	localparam int FIELD_W = 64;
	// operand width actually used by the datapath, 8 to 64
	localparam int DATA_WIDTH = 64;
	localparam int CNT_W = $clog2(DATA_WIDTH);

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_FIX
	} state_t;

	// two's complement negation within the operand width
	function automatic word_t negate_w(input word_t x);
		negate_w = (~x) + word_t'(1);
	endfunction

endpackage

// ===== design/idr_if.sv =====
// request channel: one division job
interface idr_req_if import idr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [FIELD_W-1:0] dividend;
	logic [FIELD_W-1:0] divisor;

	modport source (output valid, output req_type, output dividend, output divisor,
		input ready);
	modport sink (input valid, input req_type, input dividend, input divisor,
		output ready);
endinterface

// response channel: quotient, remainder and error flag
interface idr_rsp_if import idr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] quotient;
	logic [FIELD_W-1:0] remainder;
	logic               div_by_zero;

	modport source (output valid, output quotient, output remainder, output div_by_zero,
		input ready);
	modport sink (input valid, input quotient, input remainder, input div_by_zero,
		output ready);
endinterface

// ===== design/int64_divide_remainder.sv =====
// Restoring integer divider, one quotient bit per cycle. A request carries a
// dividend, a divisor and req_type (0 unsigned, 1 signed two's complement);
// the response carries the quotient, the remainder and div_by_zero. Signed
// division truncates toward zero and the remainder takes the dividend's sign;
// the most negative value divided by -1 wraps to itself with remainder 0. A
// zero dividend returns 0 and 0 with no error; a zero divisor with a nonzero
// dividend returns 0 and 0 with div_by_zero set. One job is in the divider at
// a time: from request transfer to the next request transfer it takes operand
// magnitudes, runs the shift-subtract loop (one quotient bit per cycle
// through a single (DATA_WIDTH+2)-bit subtractor), fixes signs, and
// returns to idle. A zero dividend or a zero divisor skips the loop. The
// result sits in an output register, so a new request is taken while the
// previous response still waits for its transfer; the sign fix-up cycle of
// that new job then holds until the output register is free.
module int64_divide_remainder import idr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	idr_req_if.sink   req,
	idr_rsp_if.source rsp
);
`include "int64_divide_remainder_defines.svh"

	localparam cnt_t LAST_CNT = cnt_t'(DATA_WIDTH - 1);

	// sequencer
	state_t state_q, state_d;
	cnt_t   cnt_q;

	// datapath registers
	word_t  rem_q;      // partial remainder
	word_t  quo_q;      // dividend bits shift out the top, quotient bits shift in
	word_t  div_q;      // divisor magnitude
	logic   sgn_q;      // signed request
	logic   neg_q_q;    // quotient gets negated
	logic   neg_r_q;    // remainder gets negated
	logic   zero_q;     // zero dividend or zero divisor, result forced to zero
	logic   err_q;      // divide by zero

	// output register
	logic               out_valid_q;
	logic [FIELD_W-1:0] out_quo_q;
	logic [FIELD_W-1:0] out_rem_q;
	logic               out_err_q;

	logic req_xfer;
	logic load_out;
	logic neg_a;
	logic neg_b;
	logic borrow;
	logic [DATA_WIDTH+1:0] trial;

	assign req_xfer = req.valid && req.ready;

	// operand signs, read while the raw operands sit in quo_q and div_q
	assign neg_a = sgn_q && quo_q[DATA_WIDTH-1];
	assign neg_b = sgn_q && div_q[DATA_WIDTH-1];

	// shift in the next dividend bit and trial-subtract the divisor
	assign trial  = {1'b0, rem_q, quo_q[DATA_WIDTH-1]} - {2'b00, div_q};
	assign borrow = trial[DATA_WIDTH+1];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				// special cases skip the loop
				if ((quo_q == '0) || (div_q == '0)) state_d = ST_FIX;
				else state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == LAST_CNT) state_d = ST_FIX;
			end
			ST_FIX: begin
				// hold until the output register frees up
				if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_FIX:  load_out  = !out_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
				load_out  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PREP) cnt_q <= '0;
			else if (state_q == ST_DIV) cnt_q <= cnt_q + cnt_t'(1);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					// bits above the operand width are dropped here
					quo_q <= req.dividend[DATA_WIDTH-1:0];
					div_q <= req.divisor[DATA_WIDTH-1:0];
					sgn_q <= req.req_type;
				end
			end
			ST_PREP: begin
				// the most negative value negates to itself, which reads as its magnitude
				quo_q   <= neg_a ? negate_w(quo_q) : quo_q;
				div_q   <= neg_b ? negate_w(div_q) : div_q;
				neg_q_q <= neg_a ^ neg_b;
				neg_r_q <= neg_a;
				zero_q  <= (quo_q == '0) || (div_q == '0);
				err_q   <= (quo_q != '0) && (div_q == '0);
				rem_q   <= '0;
			end
			ST_DIV: begin
				if (!borrow) rem_q <= trial[DATA_WIDTH-1:0];
				else rem_q <= {rem_q[DATA_WIDTH-2:0], quo_q[DATA_WIDTH-1]};
				quo_q <= {quo_q[DATA_WIDTH-2:0], !borrow};
			end
			default: begin
			end
		endcase
	end

	// output register, loaded in the sign fix-up cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (zero_q) begin
				out_quo_q <= '0;
				out_rem_q <= '0;
			end else begin
				out_quo_q <= FIELD_W'(neg_q_q ? negate_w(quo_q) : quo_q);
				out_rem_q <= FIELD_W'(neg_r_q ? negate_w(rem_q) : rem_q);
			end
			out_err_q <= err_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.quotient    = out_quo_q;
	assign rsp.remainder   = out_rem_q;
	assign rsp.div_by_zero = out_err_q;

	// a taken request always starts with the magnitude cycle
	`IDR_ASSERT_NEXT(a_xfer_to_prep, clk, arst_n, req_xfer, state_q == ST_PREP)
	// the loop ends after its last quotient bit
	`IDR_ASSERT_NEXT(a_loop_end, clk, arst_n, (state_q == ST_DIV) && (cnt_q == LAST_CNT),
		state_q == ST_FIX)
	// a finished division leaves a remainder below the divisor magnitude
	`IDR_ASSERT_NOW(a_rem_below_div, clk, arst_n, (state_q == ST_FIX) && !zero_q,
		rem_q < div_q)
	// an error response carries zero quotient and remainder
	`IDR_ASSERT_NOW(a_err_zero, clk, arst_n, rsp.valid && rsp.div_by_zero,
		(rsp.quotient == '0) && (rsp.remainder == '0))

endmodule
